/* design/lps_pkg.sv */
// Shared constants and codes for the line pixel stepper.
`default_nettype none

package lps_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_SIDE_DEF   = 4096;
    localparam int ADDR_BITS      = 24;
    localparam int COLOR_BITS     = 32;
    localparam int CFG_BITS       = 13;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_sel;

    typedef enum logic {
        MODE_START   = 1'b0,
        MODE_ADVANCE = 1'b1
    } t_mode;

endpackage

`default_nettype wire

/* design/line_pixel_stepper_top.sv */
// Bresenham line rasterizer: one pixel write per start transfer and per advance on an open line.
//
// Input stream: tuser is the mode (start a line or advance one pixel); tdata
// carries both end points and the color, read on a start transfer only. A
// start emits the first pixel, each advance while a line is open emits the
// next one. An advance with no line open emits nothing. A start always
// abandons any line in progress.
// Output stream: tdata is the linear pixel index and the color, tuser flags
// an index inside the surface, tlast marks the final pixel of the line.
// The result passes three registered stages: stage 1 registers the stepped
// pixel at the input transfer edge, stage 2 the row times width multiply,
// stage 3 the address add and bounds compare. One transfer per cycle is
// sustained in both directions while the receiver does not stall.
// When the receiver stalls, the three stages fill and then input tready
// drops; a result held in any stage is never lost or repeated.
// Reset closes any open line, empties the stages and loads the surface size
// registers with 640 by 480. The APB port sets width (offset 0) and height
// (offset 4); write them only while no line is in flight.
`default_nettype none

module line_pixel_stepper_top #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF,
    parameter int MAX_SIDE   = lps_pkg::MAX_SIDE_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    // start_x, start_y, end_x, end_y, color from the lowest bit up
    input  wire logic [((4*COORD_BITS+lps_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  wire logic                                     s_axis_tuser,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // pixel_addr, pixel_color from the lowest bit up
    output logic [lps_pkg::ADDR_BITS+lps_pkg::COLOR_BITS-1:0] m_axis_tdata,
    // write_ok
    output logic                                          m_axis_tuser,
    output logic                                          m_axis_tlast,
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [lps_pkg::APB_ADDR_BITS-1:0]        paddr,
    input  wire logic [lps_pkg::APB_DATA_BITS-1:0]        pwdata,
    output logic [lps_pkg::APB_DATA_BITS-1:0]             prdata,
    output logic                                          pready
);
    import lps_pkg::*;

    localparam int C         = COORD_BITS;
    localparam int SIDE_BITS = $clog2(MAX_SIDE + 1);
    localparam int PROD_BITS = C + SIDE_BITS + 1;
    localparam int AREA_BITS = 2 * SIDE_BITS;
    localparam int CMP_A     = (PROD_BITS + 1 > AREA_BITS + 1) ? PROD_BITS + 1 : AREA_BITS + 1;
    localparam int CMP_BITS  = (CMP_A > ADDR_BITS + 1) ? CMP_A : ADDR_BITS + 1;
    localparam logic [C-1:0] ONE = C'(1);

    // configuration
    logic [CFG_BITS-1:0]  r_width;
    logic [CFG_BITS-1:0]  r_height;
    logic [SIDE_BITS-1:0] side_w;
    logic [SIDE_BITS-1:0] side_h;
    logic [AREA_BITS-1:0] r_area;
    t_reg_sel             reg_sel;

    // line state
    logic                 r_active,  n_active;
    logic signed [C-1:0]  r_cur_col, n_cur_col;
    logic signed [C-1:0]  r_cur_row, n_cur_row;
    logic signed [C-1:0]  r_goal_col, n_goal_col;
    logic signed [C-1:0]  r_goal_row, n_goal_row;
    logic [C-1:0]         r_abs_dx,  n_abs_dx;
    logic [C-1:0]         r_abs_dy,  n_abs_dy;
    logic                 r_col_neg, n_col_neg;
    logic                 r_row_neg, n_row_neg;
    logic                 r_x_major, n_x_major;
    logic signed [C+1:0]  r_err,     n_err;
    logic [COLOR_BITS-1:0] r_color,  n_color;

    // step logic
    logic                  in_acc;
    logic                  emit;
    logic                  n_last;
    logic signed [C-1:0]   in_sx, in_sy, in_ex, in_ey;
    logic [COLOR_BITS-1:0] in_color;
    logic signed [C:0]     ddx, ddy;
    logic [C-1:0]          mag_x, mag_y;
    logic [C-1:0]          major, minor;
    logic signed [C+1:0]   err_a;

    // pipeline stages
    logic                  s1_ready, s2_ready, s3_ready;
    logic                  r1_valid, r2_valid, r3_valid;
    logic signed [C-1:0]   r1_row, r1_col, r2_col;
    logic                  r1_last, r2_last;
    logic [COLOR_BITS-1:0] r1_color, r2_color;
    logic signed [PROD_BITS-1:0] r2_prod;
    logic signed [CMP_BITS-1:0]  pos;
    logic                  pos_ok;
    logic [ADDR_BITS-1:0]  r3_addr;
    logic [COLOR_BITS-1:0] r3_color;
    logic                  r3_ok, r3_last;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_sel = t_reg_sel'(paddr[2]);

    always_comb begin
        case (reg_sel)
            REG_WIDTH:  prdata = APB_DATA_BITS'(r_width);
            REG_HEIGHT: prdata = APB_DATA_BITS'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_WIDTH:  r_width  <= pwdata[CFG_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_BITS-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    assign side_w = (32'(r_width) > 32'(MAX_SIDE)) ? SIDE_BITS'(MAX_SIDE)
                                                   : SIDE_BITS'(r_width);
    assign side_h = (32'(r_height) > 32'(MAX_SIDE)) ? SIDE_BITS'(MAX_SIDE)
                                                    : SIDE_BITS'(r_height);

    always_ff @(posedge i_clk) begin
        r_area <= AREA_BITS'(side_w) * AREA_BITS'(side_h);
    end

    // ---------------- handshake ----------------
    assign s3_ready      = !r3_valid || m_axis_tready;
    assign s2_ready      = !r2_valid || s3_ready;
    assign s1_ready      = !r1_valid || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_acc        = s_axis_tvalid && s1_ready;

    // ---------------- line step ----------------
    assign in_sx    = s_axis_tdata[C-1:0];
    assign in_sy    = s_axis_tdata[2*C-1:C];
    assign in_ex    = s_axis_tdata[3*C-1:2*C];
    assign in_ey    = s_axis_tdata[4*C-1:3*C];
    assign in_color = s_axis_tdata[4*C+COLOR_BITS-1:4*C];

    assign ddx   = {in_ex[C-1], in_ex} - {in_sx[C-1], in_sx};
    assign ddy   = {in_ey[C-1], in_ey} - {in_sy[C-1], in_sy};
    assign mag_x = ddx[C] ? C'(-ddx) : C'(ddx);
    assign mag_y = ddy[C] ? C'(-ddy) : C'(ddy);

    assign major = r_x_major ? r_abs_dx : r_abs_dy;
    assign minor = r_x_major ? r_abs_dy : r_abs_dx;
    assign err_a = r_err - $signed({2'b00, minor});

    always_comb begin
        n_active   = r_active;
        n_cur_col  = r_cur_col;
        n_cur_row  = r_cur_row;
        n_goal_col = r_goal_col;
        n_goal_row = r_goal_row;
        n_abs_dx   = r_abs_dx;
        n_abs_dy   = r_abs_dy;
        n_col_neg  = r_col_neg;
        n_row_neg  = r_row_neg;
        n_x_major  = r_x_major;
        n_err      = r_err;
        n_color    = r_color;
        emit       = 1'b0;
        if (in_acc) begin
            if (t_mode'(s_axis_tuser) == MODE_START) begin
                emit       = 1'b1;
                n_cur_col  = in_sx;
                n_cur_row  = in_sy;
                n_goal_col = in_ex;
                n_goal_row = in_ey;
                n_color    = in_color;
                n_abs_dx   = mag_x[C-1:0];
                n_abs_dy   = mag_y[C-1:0];
                n_col_neg  = ddx[C] || (ddx == '0);
                n_row_neg  = ddy[C] || (ddy == '0);
                n_x_major  = mag_x[C-1:0] > mag_y[C-1:0];
                n_err      = n_x_major ? $signed({3'b000, mag_x[C-1:1]})
                                       : $signed({3'b000, mag_y[C-1:1]});
            end else if (r_active) begin
                emit  = 1'b1;
                n_err = err_a;
                if (err_a[C+1]) begin
                    n_err = err_a + $signed({2'b00, major});
                    if (r_x_major) begin
                        n_cur_row = r_row_neg ? r_cur_row - ONE : r_cur_row + ONE;
                    end else begin
                        n_cur_col = r_col_neg ? r_cur_col - ONE : r_cur_col + ONE;
                    end
                end
                if (r_x_major) begin
                    n_cur_col = r_col_neg ? r_cur_col - ONE : r_cur_col + ONE;
                end else begin
                    n_cur_row = r_row_neg ? r_cur_row - ONE : r_cur_row + ONE;
                end
            end
        end
        n_last = n_x_major ? (n_cur_col == n_goal_col) : (n_cur_row == n_goal_row);
        if (emit) begin
            n_active = !n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
        r_cur_col  <= n_cur_col;
        r_cur_row  <= n_cur_row;
        r_goal_col <= n_goal_col;
        r_goal_row <= n_goal_row;
        r_abs_dx   <= n_abs_dx;
        r_abs_dy   <= n_abs_dy;
        r_col_neg  <= n_col_neg;
        r_row_neg  <= n_row_neg;
        r_x_major  <= n_x_major;
        r_err      <= n_err;
        r_color    <= n_color;
    end

    // ---------------- stage 1: pixel coordinates ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_ready) begin
            r1_valid <= emit;
        end
        if (s1_ready && emit) begin
            r1_row   <= n_cur_row;
            r1_col   <= n_cur_col;
            r1_last  <= n_last;
            r1_color <= n_color;
        end
    end

    // ---------------- stage 2: row times width ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_ready) begin
            r2_valid <= r1_valid;
        end
        if (s2_ready && r1_valid) begin
            r2_prod  <= PROD_BITS'(r1_row) * PROD_BITS'($signed({1'b0, side_w}));
            r2_col   <= r1_col;
            r2_last  <= r1_last;
            r2_color <= r1_color;
        end
    end

    // ---------------- stage 3: address and bounds ----------------
    assign pos    = CMP_BITS'(r2_prod) + CMP_BITS'(r2_col);
    assign pos_ok = (pos[CMP_BITS-1:ADDR_BITS] == '0)
                 && (CMP_BITS'(pos[ADDR_BITS-1:0]) < CMP_BITS'(r_area));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (s3_ready) begin
            r3_valid <= r2_valid;
        end
        if (s3_ready && r2_valid) begin
            r3_addr  <= pos[ADDR_BITS-1:0];
            r3_color <= r2_color;
            r3_ok    <= pos_ok;
            r3_last  <= r2_last;
        end
    end

    assign m_axis_tvalid = r3_valid;
    assign m_axis_tdata  = {r3_color, r3_addr};
    assign m_axis_tuser  = r3_ok;
    assign m_axis_tlast  = r3_last;

endmodule

`default_nettype wire
